// ===== hw/rtl/sfcp_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the frame packer.
package sfcp_pkg;

   localparam int unsigned NUM_CHANNELS = 4;
   localparam int unsigned DATA_BYTES   = 8;
   localparam int unsigned FRAME_BYTES  = 10;
   localparam int unsigned IDX_W        = $clog2(FRAME_BYTES);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Byte positions of the CRC trailer within a frame
   localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(DATA_BYTES);
   localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(FRAME_BYTES - 1);

   // Four channel samples, channel_a in slot 0
   typedef logic [NUM_CHANNELS-1:0][15:0] sample_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic       valid;
      sample_type data;
   } queue_head_type;

   // One reflected CRC-16 update over a byte, LSB first
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/sfcp_front.sv =====
// Front end: accepts sample transactions and holds them in a short queue.
module sfcp_front #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sfcp_pkg::sample_type    req_sample,
   output sfcp_pkg::queue_head_type head,
   input  logic                    head_take
);

   localparam int unsigned PTR_W = $clog2(DEPTH) + 1;

   sfcp_pkg::sample_type store_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] fill;
   logic             push;
   logic             pop;

   assign fill      = wr_ptr_ff - rd_ptr_ff;
   assign req_stall = (fill == PTR_W'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = head_take && head.valid;

   assign head.valid = (fill != '0);
   assign head.data  = store_ff[rd_ptr_ff[PTR_W-2:0]];

   assign wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff[PTR_W-2:0]] <= req_sample;
      end
   end

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill <= PTR_W'(DEPTH))
      else $error("queue fill beyond depth");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      head_take |-> head.valid)
      else $error("take from empty queue");

endmodule

// ===== hw/rtl/sfcp_back.sv =====
// Back end: serialises one queued transaction into a ten-byte frame with CRC trailer.
module sfcp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  sfcp_pkg::queue_head_type head,
   output logic                     head_take,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_frame_byte,
   output logic                     rsp_frame_end
);

   logic                         busy_ff, busy_in;
   logic [sfcp_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [15:0]                  crc_ff, crc_in;
   sfcp_pkg::sample_type         smp_ff;
   logic [15:0]                  cur_word;
   logic                         accept;
   logic                         last;
   logic                         load;

   assign cur_word = smp_ff[idx_ff[2:1]];

   always_comb begin
      if (idx_ff == sfcp_pkg::IDX_CRC_HI) begin
         rsp_frame_byte = crc_ff[15:8];
      end else if (idx_ff == sfcp_pkg::IDX_CRC_LO) begin
         rsp_frame_byte = crc_ff[7:0];
      end else begin
         rsp_frame_byte = idx_ff[0] ? cur_word[15:8] : cur_word[7:0];
      end
   end

   assign rsp_valid     = busy_ff;
   assign last          = (idx_ff == sfcp_pkg::IDX_CRC_HI);
   assign rsp_frame_end = last;
   assign accept        = rsp_valid && !rsp_stall;
   assign load          = head.valid && (!busy_ff || (accept && last));
   assign head_take     = load;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      crc_in  = crc_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
         crc_in  = sfcp_pkg::CRC_INIT;
      end else if (accept) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + sfcp_pkg::IDX_W'(1);
            // fold each data byte into the CRC as it leaves
            if (idx_ff < sfcp_pkg::IDX_CRC_LO) begin
               crc_in = sfcp_pkg::crc_update(crc_ff, rsp_frame_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (load) begin
         smp_ff <= head.data;
      end
   end

   a_take_when_free : assert property (@(posedge clock) disable iff (reset)
      head_take |-> (!busy_ff || (accept && last)))
      else $error("queue taken while a frame is in flight");

   a_crc_seeded : assert property (@(posedge clock) disable iff (reset)
      load |=> (crc_ff == sfcp_pkg::CRC_INIT && idx_ff == '0 && busy_ff))
      else $error("frame start not seeded");

   a_idx_step : assert property (@(posedge clock) disable iff (reset)
      (accept && !last) |=> (idx_ff == $past(idx_ff) + sfcp_pkg::IDX_W'(1)))
      else $error("byte index did not advance");

   a_idx_range : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= sfcp_pkg::IDX_CRC_HI))
      else $error("byte index out of frame");

endmodule

// ===== hw/rtl/scope_frame_crc16_packer.sv =====
// Top level of the four-channel scope frame packer with CRC-16/MODBUS trailer.
//
// Each request transaction carries four 16-bit two's-complement samples and
// produces ten response transactions, one byte each: channel_a low then high
// byte, likewise channel_b, channel_c and channel_d, then the CRC low byte and
// the CRC high byte, with rsp_frame_end set on the last. The CRC is
// CRC-16/MODBUS (reflected polynomial 0xA001, seed 0xFFFF, no final XOR) over
// the eight data bytes; it is folded in one byte per cycle while rsp_stall is
// low, as each data byte is handed over, so the trailer is ready as soon as
// the data bytes are gone. A front end takes requests into a queue of
// QUEUE_DEPTH entries (a power of two, at least 2) and stalls only when that
// queue is full; a back end pulls one entry at a time and emits its frame at
// one byte per cycle while rsp_stall is low. It loads the next queued entry as
// the last byte of a frame is taken, so frames abut when one is waiting. A
// request is written into the queue and, when the back end is free, loaded
// into the back end's sample register, from which the first byte of its frame
// is offered. Response stall only holds the back end; requests keep being
// taken until the queue fills. Nothing is kept between frames.
module scope_frame_crc16_packer #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_channel_a,
   input  logic signed [15:0] req_channel_b,
   input  logic signed [15:0] req_channel_c,
   input  logic signed [15:0] req_channel_d,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_frame_byte,
   output logic               rsp_frame_end
);

   sfcp_pkg::sample_type     req_sample;
   sfcp_pkg::queue_head_type head;
   logic                     head_take;

   // Pack the samples as raw 16-bit patterns, channel_a in slot 0
   assign req_sample = {req_channel_d, req_channel_c, req_channel_b, req_channel_a};

   sfcp_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .head       (head),
      .head_take  (head_take)
   );

   // Hold each frame until the consumer drains it; advance one byte per accept
   sfcp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_take      (head_take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

// ===== tb/scope_frame_crc16_packer_tb.sv =====
// Testbench for the four-channel scope frame packer with CRC-16/MODBUS trailer.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam int unsigned MAX_REPORTS = 10;
   localparam int unsigned HOLD_OFF    = 400;

   // One byte of a frame as it should leave the block
   typedef struct {
      logic [7:0] data;
      logic       last;
   } frame_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid     = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_channel_a = '0;
   logic signed [15:0] req_channel_b = '0;
   logic signed [15:0] req_channel_c = '0;
   logic signed [15:0] req_channel_d = '0;
   logic               rsp_valid;
   logic               rsp_stall     = 1'b0;
   logic [7:0]         rsp_frame_byte;
   logic               rsp_frame_end;

   // Bytes still owed by the block, oldest first
   frame_beat_type frame_bytes_due[$];

   int unsigned cycle_count    = 0;
   int unsigned fail_count     = 0;
   int unsigned frames_sent    = 0;
   int unsigned bytes_checked  = 0;
   int unsigned input_stalls   = 0;

   // Sender and receiver idling controls
   bit          tx_jitter      = 1'b0;
   bit          rx_jitter      = 1'b0;
   int unsigned rx_hold_cycles = 0;
   int unsigned rx_stall_run   = 0;
   int unsigned rx_free_run    = 0;

   scope_frame_crc16_packer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_channel_a  (req_channel_a),
      .req_channel_b  (req_channel_b),
      .req_channel_c  (req_channel_c),
      .req_channel_d  (req_channel_d),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_end  (rsp_frame_end)
   );

   always #10 clock = ~clock;

   // Bound the run: a hung handshake ends here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d bytes outstanding",
                  cycle_count, frame_bytes_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Gap lengths: drawn from three ranges, mostly the shortest, rarely the longest
   function automatic int unsigned pick_gap_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return $urandom_range(1, 3);
      end else if (roll < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Sample values lean on the extremes so the sign bit and all-ones cases recur
   function automatic logic [15:0] random_sample();
      case ($urandom_range(0, 9))
         0: begin
            return 16'h8000;
         end
         1: begin
            return 16'h7FFF;
         end
         2: begin
            return 16'h0000;
         end
         3: begin
            return 16'hFFFF;
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   // CRC-16/MODBUS over the eight data bytes, folded one bit at a time, LSB first
   function automatic logic [15:0] modbus_crc_of(input logic [63:0] payload);
      logic [15:0] crc;
      logic        feedback;
      crc = sfcp_pkg::CRC_INIT;
      for (int i = 0; i < 64; i++) begin
         feedback = crc[0] ^ payload[i];
         crc      = crc >> 1;
         if (feedback) begin
            crc = crc ^ sfcp_pkg::CRC_POLY;
         end
      end
      return crc;
   endfunction

   // Work out the ten bytes that one accepted sample set must produce
   function automatic void predict_frame(input logic [15:0] a, b, c, d);
      logic [63:0]     payload;
      logic [15:0]     crc;
      logic [79:0]     frame;
      frame_beat_type  beat;
      // channel_a occupies byte 0 (low) and byte 1 (high), then b, c, d
      payload = {d, c, b, a};
      crc     = modbus_crc_of(payload);
      frame   = {crc, payload};
      for (int k = 0; k < sfcp_pkg::FRAME_BYTES; k++) begin
         beat.data = frame[8*k +: 8];
         beat.last = (k == sfcp_pkg::FRAME_BYTES - 1);
         frame_bytes_due.push_back(beat);
      end
   endfunction

   task automatic log_mismatch(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("ERROR cycle %0d: %s", cycle_count, what);
      end
   endtask

   // Offer one transaction and hold it until the block takes it
   task automatic send_samples(input logic [15:0] a, b, c, d);
      @(negedge clock);
      req_valid     = 1'b1;
      req_channel_a = a;
      req_channel_b = b;
      req_channel_c = c;
      req_channel_d = d;
      forever begin
         @(posedge clock);
         if (!req_stall) begin
            break;
         end
         input_stalls++;
      end
      predict_frame(a, b, c, d);
      frames_sent++;
   endtask

   // Drop valid for a number of cycles, scrambling the idle payload
   task automatic tx_idle(input int unsigned cycles);
      if (cycles == 0) begin
         return;
      end
      @(negedge clock);
      req_valid     = 1'b0;
      req_channel_a = 16'($urandom);
      req_channel_b = 16'($urandom);
      req_channel_c = 16'($urandom);
      req_channel_d = 16'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic tx_random_gap();
      if (tx_jitter && $urandom_range(0, 99) < 45) begin
         tx_idle(pick_gap_length());
      end
   endtask

   task automatic send_random_samples();
      send_samples(random_sample(), random_sample(), random_sample(), random_sample());
      tx_random_gap();
   endtask

   task automatic wait_for_drain();
      while (frame_bytes_due.size() != 0) @(posedge clock);
   endtask

   // Receiver back-pressure: a long hold-off takes priority over random stalls
   always @(negedge clock) begin
      if (rx_hold_cycles != 0) begin
         rsp_stall = 1'b1;
         rx_hold_cycles--;
      end else if (!rx_jitter) begin
         rsp_stall = 1'b0;
      end else if (rx_stall_run != 0) begin
         rsp_stall = 1'b1;
         rx_stall_run--;
      end else if (rx_free_run != 0) begin
         rsp_stall = 1'b0;
         rx_free_run--;
      end else begin
         rsp_stall    = 1'b0;
         rx_stall_run = pick_gap_length();
         rx_free_run  = $urandom_range(0, 15);
      end
   end

   // Compare every accepted response transaction against the oldest owed byte
   always @(posedge clock) begin
      frame_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         bytes_checked++;
         if (frame_bytes_due.size() == 0) begin
            log_mismatch($sformatf("unexpected byte %02h end=%0b",
                                   rsp_frame_byte, rsp_frame_end));
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_frame_byte !== want.data) begin
               log_mismatch($sformatf("frame_byte expected %02h got %02h",
                                      want.data, rsp_frame_byte));
            end
            if (rsp_frame_end !== want.last) begin
               log_mismatch($sformatf("frame_end expected %0b got %0b",
                                      want.last, rsp_frame_end));
            end
         end
      end
   end

   // Extremes of every field, each byte lane distinct, all bits at both values
   task automatic test_directed_patterns();
      tx_jitter = 1'b0;
      rx_jitter = 1'b0;
      send_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_samples(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_samples(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_samples(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_samples(16'h0102, 16'h0304, 16'h0506, 16'h0708);
      send_samples(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
      send_samples(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_samples(16'h00FF, 16'hFF00, 16'hFF00, 16'h00FF);
      send_samples(16'hFFFE, 16'hFF85, 16'hC000, 16'h8001);
      send_samples(16'h0001, 16'h0002, 16'h0004, 16'h0008);
      send_samples(16'h1000, 16'h2000, 16'h4000, 16'h8000);
      send_samples(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
      send_samples(16'hA001, 16'hFFFF, 16'h0000, 16'hA001);
      tx_idle(1);
      wait_for_drain();
   endtask

   // Back-to-back transactions with neither side idling, so frames abut
   task automatic test_steady_stream();
      tx_jitter = 1'b0;
      rx_jitter = 1'b0;
      repeat (40) send_random_samples();
      tx_idle(1);
      wait_for_drain();
   endtask

   // Hold the receiver off while requests keep coming, so the queue fills
   task automatic test_receiver_hold_off();
      tx_jitter = 1'b0;
      rx_jitter = 1'b0;
      @(posedge clock);
      rx_hold_cycles = HOLD_OFF;
      repeat (16) send_random_samples();
      tx_idle(1);
      wait_for_drain();
   endtask

   // Let the block empty completely mid-stream, then pick up again
   task automatic test_pause_and_resume();
      tx_jitter = 1'b1;
      rx_jitter = 1'b1;
      repeat (15) send_random_samples();
      tx_idle(1);
      wait_for_drain();
      tx_idle($urandom_range(1, 8));
      repeat (15) send_random_samples();
      tx_idle(1);
      wait_for_drain();
   endtask

   // Bulk random traffic; idling on each side switches on and off in stretches
   task automatic test_random_traffic();
      for (int n = 0; n < 180; n++) begin
         if (n % 30 == 0) begin
            tx_jitter = ($urandom_range(0, 3) != 0);
            rx_jitter = ($urandom_range(0, 3) != 0);
         end
         send_random_samples();
      end
      tx_idle(1);
      wait_for_drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_patterns();
      test_steady_stream();
      test_receiver_hold_off();
      test_pause_and_resume();
      test_random_traffic();

      // Anything arriving now is surplus and is caught by the checker
      repeat (30) @(posedge clock);
      if (frame_bytes_due.size() != 0) begin
         log_mismatch($sformatf("%0d bytes never arrived", frame_bytes_due.size()));
      end

      $display("Run covered %0d frames, %0d bytes checked, %0d mismatches",
               frames_sent, bytes_checked, fail_count);
      $display("Input held back for %0d cycles; receiver held off once for %0d cycles",
               input_stalls, HOLD_OFF);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
